[sv/header_check_keystream_decrypt_macros.svh]
// Assertion macros shared by the header check and keystream decrypt RTL.
`ifndef HEADER_CHECK_KEYSTREAM_DECRYPT_MACROS_SVH
`define HEADER_CHECK_KEYSTREAM_DECRYPT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HCKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HCKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hckd_pkg.sv]
// Types, constants and helpers of the header check and keystream decrypt block.
package hckd_pkg;

    localparam logic [4:0]  HDR_LAST_IDX   = 5'd23;
    localparam logic [7:0]  VERSION_WANTED = 8'h01;
    localparam logic [7:0]  FLAG_WANTED    = 8'h01;
    localparam logic [63:0] KEY_SEED       = 64'hD6E8_FEB8_6659_FD93;
    localparam logic [63:0] STREAM_MUL     = 64'h2545_F491_4F6C_DD1D;
    localparam logic [63:0] STREAM_FALLBK  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0] MAX_SIZE_RST   = 32'h2000_0000;
    localparam logic [7:0]  MAGIC [4]      = '{8'h4C, 8'h44, 8'h44, 8'h43};

    typedef enum logic [1:0] {
        KIND_INFO,
        KIND_DATA,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TRUNC,
        ST_MAGIC,
        ST_VERSION,
        ST_FLAGS,
        ST_TOO_LARGE,
        ST_EMPTY
    } t_status;

    // Code 3 is unused and behaves as discard.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DISCARD
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [7:0]  data_byte;
        logic [31:0] declared_size;
        logic [31:0] expected_crc;
        logic        out_last;
    } t_out_word;

    // Result on its way to the output register; key_idx picks the key byte.
    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [7:0]  data_byte;
        logic [31:0] declared_size;
        logic [31:0] expected_crc;
        logic        out_last;
        logic [2:0]  key_idx;
    } t_stage;

    function automatic logic [63:0] xorshift64(input logic [63:0] s);
        logic [63:0] a;
        logic [63:0] b;
        a = s ^ (s >> 12);
        b = a ^ (a << 25);
        return b ^ (b >> 27);
    endfunction

endpackage

[sv/header_check_keystream_decrypt.sv]
// Top level: container header check and xorshift64* keystream decryption.
//
// Takes one file byte per cycle and gives at most one result per byte, passed
// via the stage one, two and three registers. The rate is one byte per cycle
// without gaps, stalling only while the output register holds a word not yet
// taken. Stage one parses the header and steps the xorshift state once per
// eight payload bytes; stage two forms three 32x32 partial products of the
// 64-bit keystream multiply; stage three adds them, selects the key byte and
// XORs it into the payload byte. The 24-byte header gives one info word when
// good, or one error word, after which bytes are dropped until the last mark.
// max_size may be written at any time the block holds no word in flight.
module header_check_keystream_decrypt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hckd_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hckd_pkg::t_out_word o_out,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import hckd_pkg::*;

    localparam logic [31:0] MUL_LO = STREAM_MUL[31:0];
    localparam logic [31:0] MUL_HI = STREAM_MUL[63:32];

    logic [31:0] r_max_size;
    logic [4:0]  r_hdr_cnt, n_hdr_cnt;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_ok, n_ok;
    logic [31:0] r_size, n_size;
    logic [31:0] r_crc, n_crc;
    logic [63:0] r_nonce, n_nonce;
    logic [63:0] r_stream, n_stream;
    logic [2:0]  r_blk_idx, n_blk_idx;

    t_stage      r_st1, n_st1;
    logic        r_v1, n_v1;
    logic [63:0] r_s1, n_s1;
    t_stage      r_st2;
    logic        r_v2;
    logic [63:0] r_p0;
    logic [31:0] r_p1, r_p2;
    logic [63:0] r_key_block;
    t_out_word   r_out;
    logic        r_v3;

    logic        w_adv;
    logic        w_acc;
    logic [63:0] w_seed;
    logic [63:0] w_sum;
    logic [63:0] w_key;

    assign w_adv       = !r_v3 || i_out_ready;
    assign w_acc       = i_in_valid && w_adv;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_v3;
    assign o_out       = r_out;

    assign w_seed = {i_in.in_byte, r_nonce[55:0]} ^ KEY_SEED;

    // Stage one: header parse and keystream state step.
    always_comb begin
        logic       start;
        logic [4:0] c;
        logic [7:0] b;
        t_status    st;
        start     = 1'b0;
        c         = r_hdr_cnt;
        b         = i_in.in_byte;
        st        = ST_OK;
        n_hdr_cnt = r_hdr_cnt;
        n_phase   = r_phase;
        n_ok      = r_ok;
        n_size    = r_size;
        n_crc     = r_crc;
        n_nonce   = r_nonce;
        n_stream  = r_stream;
        n_blk_idx = r_blk_idx;
        n_s1      = r_s1;
        n_v1      = 1'b0;
        n_st1     = '{kind: KIND_INFO, status: ST_OK, data_byte: 8'h00,
                      declared_size: 32'h0, expected_crc: 32'h0,
                      out_last: 1'b0, key_idx: 3'd0};
        if (w_acc) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (c < 5'd4) begin
                        if (b != MAGIC[c[1:0]]) n_ok[0] = 1'b0;
                    end else if (c == 5'd4) begin
                        if (b != VERSION_WANTED) n_ok[1] = 1'b0;
                    end else if (c == 5'd5) begin
                        if (b != FLAG_WANTED) n_ok[2] = 1'b0;
                    end else if (c < 5'd8) begin
                        if (b != 8'h00) n_ok[2] = 1'b0;
                    end else if (c < 5'd12) begin
                        n_size[{c[1:0], 3'b000} +: 8] = b;
                    end else if (c < 5'd16) begin
                        n_crc[{c[1:0], 3'b000} +: 8] = b;
                    end else begin
                        n_nonce[{c[2:0], 3'b000} +: 8] = b;
                    end

                    if (c != HDR_LAST_IDX) begin
                        n_hdr_cnt = c + 5'd1;
                        if (i_in.in_last) begin
                            n_v1           = 1'b1;
                            n_st1.kind     = KIND_ERROR;
                            n_st1.status   = ST_TRUNC;
                            n_st1.out_last = 1'b1;
                            start          = 1'b1;
                        end
                    end else begin
                        if (!n_ok[0])                st = ST_MAGIC;
                        else if (!n_ok[1])           st = ST_VERSION;
                        else if (!n_ok[2])           st = ST_FLAGS;
                        else if (r_size > r_max_size) st = ST_TOO_LARGE;
                        else if (i_in.in_last)       st = ST_EMPTY;
                        n_v1 = 1'b1;
                        if (st != ST_OK) begin
                            n_st1.kind     = KIND_ERROR;
                            n_st1.status   = st;
                            n_st1.out_last = 1'b1;
                            if (i_in.in_last) start = 1'b1;
                            else n_phase = PH_DISCARD;
                        end else begin
                            n_st1.declared_size = r_size;
                            n_st1.expected_crc  = r_crc;
                            n_stream  = (w_seed == 64'h0) ? STREAM_FALLBK : w_seed;
                            n_blk_idx = 3'd0;
                            n_hdr_cnt = 5'd0;
                            n_phase   = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    // Step the state at the start of each eight-byte key block.
                    if (r_blk_idx == 3'd0) begin
                        n_stream = xorshift64(r_stream);
                        n_s1     = n_stream;
                    end
                    n_v1            = 1'b1;
                    n_st1.kind      = KIND_DATA;
                    n_st1.data_byte = b;
                    n_st1.out_last  = i_in.in_last;
                    n_st1.key_idx   = r_blk_idx;
                    n_blk_idx       = r_blk_idx + 3'd1;
                    if (i_in.in_last) start = 1'b1;
                end
                default: begin
                    if (i_in.in_last) start = 1'b1;
                end
            endcase
        end
        if (start) begin
            n_hdr_cnt = 5'd0;
            n_phase   = PH_HEADER;
            n_ok      = 3'b111;
            n_blk_idx = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RST;
            r_hdr_cnt  <= 5'd0;
            r_phase    <= PH_HEADER;
            r_ok       <= 3'b111;
            r_blk_idx  <= 3'd0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_size <= i_cfg_wdata;
            r_hdr_cnt <= n_hdr_cnt;
            r_phase   <= n_phase;
            r_ok      <= n_ok;
            r_blk_idx <= n_blk_idx;
            if (w_adv) begin
                r_v1 <= n_v1;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // Header words and keystream state change only on an accepted word.
    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_crc    <= n_crc;
        r_nonce  <= n_nonce;
        r_stream <= n_stream;
    end

    // Stage two: partial products of the low 64 bits of state * multiplier.
    // Stage three: sum, key byte select, XOR.
    assign w_sum = r_p0 + {r_p1 + r_p2, 32'h0};
    assign w_key = (r_st2.key_idx == 3'd0) ? w_sum : r_key_block;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st1 <= n_st1;
            r_s1  <= n_s1;
            r_st2 <= r_st1;
            r_p0  <= r_s1[31:0] * MUL_LO;
            r_p1  <= r_s1[63:32] * MUL_LO;
            r_p2  <= r_s1[31:0] * MUL_HI;
            if (r_v2 && r_st2.kind == KIND_DATA && r_st2.key_idx == 3'd0) begin
                r_key_block <= w_sum;
            end
            r_out.kind          <= r_st2.kind;
            r_out.status        <= r_st2.status;
            r_out.declared_size <= r_st2.declared_size;
            r_out.expected_crc  <= r_st2.expected_crc;
            r_out.out_last      <= r_st2.out_last;
            if (r_st2.kind == KIND_DATA) begin
                r_out.data_byte <= r_st2.data_byte ^ w_key[{r_st2.key_idx, 3'b000} +: 8];
            end else begin
                r_out.data_byte <= r_st2.data_byte;
            end
        end
    end

`include "header_check_keystream_decrypt_macros.svh"

    `HCKD_ASSERT_NOW(a_err_last, i_clk, i_rst_n, r_v3 && r_out.kind == KIND_ERROR, r_out.out_last, "error word without last mark")
    `HCKD_ASSERT_NOW(a_info_ok, i_clk, i_rst_n, r_v3 && r_out.kind == KIND_INFO, r_out.status == ST_OK && !r_out.out_last, "bad info word")
    `HCKD_ASSERT_NOW(a_payload_cnt, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_hdr_cnt == 5'd0, "header count not cleared in payload")
    `HCKD_ASSERT_NEXT(a_hdr_step, i_clk, i_rst_n, w_acc && r_phase == PH_HEADER && !i_in.in_last && r_hdr_cnt != HDR_LAST_IDX, r_hdr_cnt == $past(r_hdr_cnt) + 5'd1, "header count did not advance")
    `HCKD_ASSERT_NEXT(a_stall_key, i_clk, i_rst_n, r_v3 && !i_out_ready, $stable(r_key_block) && $stable(r_st2), "pipeline moved during stall")

endmodule

[bench/testbench.sv]
// Testbench for the header check and keystream decrypt block: file table, random files, checking.
`timescale 1ns / 100ps

module testbench;
    import hckd_pkg::*;

    localparam int          HDR_BYTES    = 24;
    localparam logic [31:0] SIG_WORD     = 32'h4344_444C;   // magic, first byte in the low bits
    localparam logic [7:0]  HDR_VERSION  = 8'h01;
    localparam logic [7:0]  HDR_FLAGS    = 8'h01;
    localparam logic [63:0] KS_SEED      = 64'hD6E8_FEB8_6659_FD93;
    localparam logic [63:0] KS_MUL       = 64'h2545_F491_4F6C_DD1D;
    localparam logic [63:0] KS_FALLBACK  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0] LIMIT_RESET  = 32'h2000_0000;
    localparam logic [7:0]  NO_FAULT     = 8'hFF;
    localparam int          RANDOM_BYTES = 1100;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          N_CASES      = 15;

    typedef struct packed {
        logic        set_lim;
        logic [31:0] lim_val;
        logic [31:0] size;
        logic [31:0] crc;
        logic [63:0] nonce;
        logic [7:0]  bad_pos;   // NO_FAULT leaves the header intact
        logic [7:0]  bad_val;
        logic [7:0]  n_pay;
        logic [7:0]  cut_to;    // zero sends the whole file
        t_status     want;      // ST_OK leaves the result to the predictor
    } t_file_case;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    // predictor state
    logic [31:0] lim;
    int          hdr_pos;
    t_phase      ph;
    logic [2:0]  hdr_good;
    logic [31:0] size_acc;
    logic [31:0] crc_acc;
    logic [63:0] nonce_acc;
    logic [63:0] ks_state;
    logic [63:0] ks_block;
    logic [2:0]  ks_pos;

    t_out_word  expected_words [$];
    t_file_case file_cases [N_CASES];
    int         mismatches  = 0;
    int         words_seen  = 0;
    int         sent_count  = 0;
    int         cycle_count = 0;
    int         hold_left   = 0;
    bit         hold_req    = 1'b0;
    bit         calm        = 1'b0;

    header_check_keystream_decrypt dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     expected_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void start_new_file();
        hdr_pos   = 0;
        ph        = PH_HEADER;
        hdr_good  = 3'b111;
        size_acc  = '0;
        crc_acc   = '0;
        nonce_acc = '0;
        ks_state  = '0;
        ks_block  = '0;
        ks_pos    = '0;
    endfunction

    task automatic decrypt_step(input logic [7:0] b, input logic l, output bit has,
                                output t_out_word r);
        int          c;
        t_status     st;
        logic [63:0] s;
        has = 1'b0;
        r   = '0;
        if (ph == PH_HEADER) begin
            c = hdr_pos;
            if (c < 4) begin
                if (b != SIG_WORD[8*c +: 8]) hdr_good[0] = 1'b0;
            end else if (c == 4) begin
                if (b != HDR_VERSION) hdr_good[1] = 1'b0;
            end else if (c == 5) begin
                if (b != HDR_FLAGS) hdr_good[2] = 1'b0;
            end else if (c < 8) begin
                if (b != 8'h00) hdr_good[2] = 1'b0;
            end else if (c < 12) begin
                size_acc[8*(c-8) +: 8] = b;
            end else if (c < 16) begin
                crc_acc[8*(c-12) +: 8] = b;
            end else begin
                nonce_acc[8*(c-16) +: 8] = b;
            end
            if (c + 1 < HDR_BYTES) begin
                hdr_pos = c + 1;
                if (l) begin
                    has        = 1'b1;
                    r.kind     = KIND_ERROR;
                    r.status   = ST_TRUNC;
                    r.out_last = 1'b1;
                    start_new_file();
                end
                return;
            end
            if (!hdr_good[0])           st = ST_MAGIC;
            else if (!hdr_good[1])      st = ST_VERSION;
            else if (!hdr_good[2])      st = ST_FLAGS;
            else if (size_acc > lim)    st = ST_TOO_LARGE;
            else if (l)                 st = ST_EMPTY;
            else                        st = ST_OK;
            has = 1'b1;
            if (st != ST_OK) begin
                r.kind     = KIND_ERROR;
                r.status   = st;
                r.out_last = 1'b1;
                if (l) start_new_file();
                else ph = PH_DISCARD;
                return;
            end
            r.kind          = KIND_INFO;
            r.status        = ST_OK;
            r.declared_size = size_acc;
            r.expected_crc  = crc_acc;
            ks_state = nonce_acc ^ KS_SEED;
            if (ks_state == 64'h0) ks_state = KS_FALLBACK;
            ks_pos  = '0;
            hdr_pos = 0;
            ph      = PH_PAYLOAD;
        end else if (ph == PH_PAYLOAD) begin
            // fresh key block on every eighth payload byte
            if (ks_pos == 3'd0) begin
                s = ks_state;
                s = s ^ (s >> 12);
                s = s ^ (s << 25);
                s = s ^ (s >> 27);
                ks_state = s;
                ks_block = s * KS_MUL;
            end
            has         = 1'b1;
            r.kind      = KIND_DATA;
            r.status    = ST_OK;
            r.data_byte = b ^ ks_block[8*ks_pos +: 8];
            r.out_last  = l;
            ks_pos      = ks_pos + 3'd1;
            if (l) start_new_file();
        end else begin
            if (l) start_new_file();
        end
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < 40)
            $display("mismatch on word %0d, %s: got %0h, want %0h", words_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin : check_words
        t_out_word want_w;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                note_mismatch("word with nothing expected", 64'(out_word.kind), 64'h0);
            end else begin
                want_w = expected_words.pop_front();
                if (out_word.kind !== want_w.kind)
                    note_mismatch("kind", 64'(out_word.kind), 64'(want_w.kind));
                if (out_word.status !== want_w.status)
                    note_mismatch("status", 64'(out_word.status), 64'(want_w.status));
                if (out_word.data_byte !== want_w.data_byte)
                    note_mismatch("data_byte", 64'(out_word.data_byte),
                                  64'(want_w.data_byte));
                if (out_word.declared_size !== want_w.declared_size)
                    note_mismatch("declared_size", 64'(out_word.declared_size),
                                  64'(want_w.declared_size));
                if (out_word.expected_crc !== want_w.expected_crc)
                    note_mismatch("expected_crc", 64'(out_word.expected_crc),
                                  64'(want_w.expected_crc));
                if (out_word.out_last !== want_w.out_last)
                    note_mismatch("out_last", 64'(out_word.out_last), 64'(want_w.out_last));
            end
            words_seen++;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99, 0) >= 24);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic l, input t_status typed);
        bit        has;
        t_out_word w;
        while (!calm && $urandom_range(99, 0) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= {b, l};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
        decrypt_step(b, l, has, w);
        if (has) begin
            if (typed != ST_OK && w.kind == KIND_ERROR) begin
                w = '0;
                w.kind     = KIND_ERROR;
                w.status   = typed;
                w.out_last = 1'b1;
            end
            expected_words.insert(expected_words.size(), w);
        end
    endtask

    // hold input until every word is out and the pipeline has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim = v;
    endtask

    task automatic send_file(input logic [31:0] size, input logic [31:0] crc,
                             input logic [63:0] nonce, input int bad_pos,
                             input logic [7:0] bad_val, input int n_pay, input int cut_to,
                             input bit rnd_pay, input t_status typed);
        logic [7:0]   img [$];
        logic [191:0] hdr;
        hdr = {nonce, crc, size, 8'h00, 8'h00, HDR_FLAGS, HDR_VERSION, SIG_WORD};
        for (int i = 0; i < HDR_BYTES; i++) img.insert(img.size(), hdr[8*i +: 8]);
        if (bad_pos < HDR_BYTES) img[bad_pos] = bad_val;
        for (int i = 0; i < n_pay; i++)
            img.insert(img.size(), rnd_pay ? 8'($urandom) : (i[0] ? 8'hFF : 8'h00));
        if (cut_to > 0)
            while (img.size() > cut_to) void'(img.pop_back());
        for (int i = 0; i < img.size(); i++)
            push_byte(img[i], i == img.size() - 1, typed);
    endtask

    task automatic random_file();
        int          r;
        int          n_pay;
        int          cut_to;
        int          bad_pos;
        int          n_noise;
        logic [31:0] size;
        r       = $urandom_range(99, 0);
        bad_pos = int'(NO_FAULT);
        cut_to  = 0;
        n_pay   = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
        size    = ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(lim, 0);
        if (r < 8) begin
            bad_pos = $urandom_range(7, 0);
        end else if (r < 14) begin
            cut_to = $urandom_range(HDR_BYTES - 1, 1);
        end else if (r < 18) begin
            n_pay = 0;
        end else if (r < 22) begin
            // noise: random bytes closed by a last mark
            n_noise = $urandom_range(30, 1);
            for (int i = 0; i < n_noise; i++)
                push_byte(8'($urandom), i == n_noise - 1, ST_OK);
            return;
        end
        send_file(size, $urandom, {$urandom, $urandom}, bad_pos, 8'($urandom), n_pay, cut_to,
                  1'b1, ST_OK);
    endtask

    initial begin
        int          dir_bytes;
        int          file_no;
        bit          hold_done;
        logic [31:0] pick;
        lim = LIMIT_RESET;
        start_new_file();
        file_cases[0]  = '{1'b0, 32'h0, LIMIT_RESET, 32'h0, 64'h0,
                           NO_FAULT, 8'h00, 8'd20, 8'd0, ST_OK};
        file_cases[1]  = '{1'b0, 32'h0, 32'h10, 32'hFFFF_FFFF, KS_SEED,
                           NO_FAULT, 8'h00, 8'd9, 8'd0, ST_OK};
        file_cases[2]  = '{1'b0, 32'h0, 32'h0, 32'h0, 64'h0,
                           NO_FAULT, 8'h00, 8'd0, 8'd1, ST_TRUNC};
        file_cases[3]  = '{1'b0, 32'h0, 32'h0, 32'h0, 64'h0,
                           NO_FAULT, 8'h00, 8'd0, 8'd23, ST_TRUNC};
        file_cases[4]  = '{1'b0, 32'h0, 32'h5, 32'h0, 64'h1,
                           8'd2, 8'h00, 8'd5, 8'd0, ST_MAGIC};
        file_cases[5]  = '{1'b0, 32'h0, 32'h5, 32'h0, 64'h1,
                           8'd4, 8'h02, 8'd0, 8'd0, ST_VERSION};
        file_cases[6]  = '{1'b0, 32'h0, 32'h5, 32'h0, 64'h1,
                           8'd5, 8'h00, 8'd3, 8'd0, ST_FLAGS};
        file_cases[7]  = '{1'b0, 32'h0, 32'h5, 32'h0, 64'h1,
                           8'd7, 8'h80, 8'd3, 8'd0, ST_FLAGS};
        file_cases[8]  = '{1'b0, 32'h0, LIMIT_RESET + 32'd1, 32'h0, 64'h2,
                           NO_FAULT, 8'h00, 8'd4, 8'd0, ST_TOO_LARGE};
        file_cases[9]  = '{1'b0, 32'h0, 32'h7, 32'h1234_5678, 64'h3,
                           NO_FAULT, 8'h00, 8'd0, 8'd0, ST_EMPTY};
        file_cases[10] = '{1'b1, 32'h0, 32'h0, 32'h0, 64'h4,
                           NO_FAULT, 8'h00, 8'd3, 8'd0, ST_OK};
        file_cases[11] = '{1'b0, 32'h0, 32'h1, 32'h0, 64'h4,
                           NO_FAULT, 8'h00, 8'd0, 8'd0, ST_TOO_LARGE};
        file_cases[12] = '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                           NO_FAULT, 8'h00, 8'd17, 8'd0, ST_OK};
        file_cases[13] = '{1'b0, 32'h0, 32'h0, 32'h0, 64'h0,
                           8'd0, 8'hFF, 8'd0, 8'd0, ST_MAGIC};
        file_cases[14] = '{1'b1, LIMIT_RESET, 32'h0, 32'h0, 64'h0123_4567_89AB_CDEF,
                           NO_FAULT, 8'h00, 8'd16, 8'd0, ST_OK};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_CASES; i++) begin
            if (file_cases[i].set_lim) write_limit(file_cases[i].lim_val);
            send_file(file_cases[i].size, file_cases[i].crc, file_cases[i].nonce,
                      int'(file_cases[i].bad_pos), file_cases[i].bad_val,
                      int'(file_cases[i].n_pay), int'(file_cases[i].cut_to), 1'b0,
                      file_cases[i].want);
        end

        dir_bytes = sent_count;
        file_no   = 0;
        hold_done = 1'b0;
        while (sent_count < dir_bytes + RANDOM_BYTES) begin
            calm = (sent_count >= dir_bytes + 600) && (sent_count < dir_bytes + 900);
            if (!hold_done && sent_count >= dir_bytes + 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (file_no % 6 == 5) begin
                case ($urandom_range(4, 0))
                    0:       pick = 32'h0;
                    1:       pick = 32'hFFFF_FFFF;
                    2:       pick = LIMIT_RESET;
                    3:       pick = $urandom;
                    default: pick = $urandom_range(255, 0);
                endcase
                write_limit(pick);
            end
            random_file();
            file_no++;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
